[hw/rtl/empv_pkg.sv]
// ----------------------------------------------------------------------------
// empv_pkg: shared types and constants
// Widths, request and status codes, controller states and command bundles.
// ----------------------------------------------------------------------------
package empv_pkg;

    localparam int MAX_BACKGROUND_DEF = 4096;
    localparam int SCORE_WIDTH_DEF    = 32;
    localparam int PV_W               = 25;
    localparam int RANK_W             = 13;
    localparam int ONE_Q24            = 16777216;
    localparam logic [PV_W-1:0] P_FLOOR_RST = 25'd17;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture request
        logic srch_init;    // start a bound search (strict selects lower bound)
        logic strict;
        logic rd_mid;       // read entry at search midpoint
        logic srch_step;    // apply compare to lo/hi
        logic save_low;     // keep finished lower bound
        logic shift_init;   // shift pointer := count
        logic rd_shift;     // read entry ptr-1
        logic wr_shift;     // write entry ptr, ptr--
        logic put;          // write key at pos, count++
        logic clear;        // count := 0
        logic div_init;
        logic div_step;
        logic fin;          // form result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic srch_done;
        logic shift_done;
        logic div_done;
        logic full;
        logic empty;
    } stat_t;

endpackage

[hw/rtl/empirical_midrank_p_value_top.sv]
// ----------------------------------------------------------------------------
// empirical_midrank_p_value_top: mid-rank p-value against a sorted store
// Clear / insert / query requests on a stream; one result per request.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                    | tuser
//  s_      | in        | score[31:0]              | req_type[1:0]
//  m_      | out       | p_value, lower, upper    | status[1:0]
//  cfg     | in        | p_floor[24:0]            | -
//
//  One transaction at a time. Query: two binary searches (lower bound,
//  then upper bound) plus a serial divide that forms 25 quotient bits.
//  Insert: one search plus a read and a write per shifted entry.
//  Clear: no search; the count is zeroed and the result is formed.
//  The store memory's single read port serializes these steps.
//  Reset (synchronous, aresetn low) empties the store and sets p_floor to 17.
//  A stalled result holds in the output registers until m_tready.
module empirical_midrank_p_value_top #(
    parameter int MAX_BACKGROUND = empv_pkg::MAX_BACKGROUND_DEF,
    parameter int SCORE_WIDTH    = empv_pkg::SCORE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [SCORE_WIDTH-1:0] s_tdata,  // score
    input  logic [1:0]  s_tuser,             // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // p_value[24:0], lower_rank[37:25], upper_rank[50:38]
    output logic [1:0]  m_tuser,  // status
    input  logic        cfg_we,
    input  logic [24:0] cfg_wdata // p_floor
);
    empv_pkg::cmd_t  cmd;
    empv_pkg::stat_t st;
    logic [24:0] p_floor_reg;
    logic [24:0] pv;
    logic [12:0] lr, ur;
    logic in_fire, out_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) p_floor_reg <= empv_pkg::P_FLOOR_RST;
        else if (cfg_we) p_floor_reg <= cfg_wdata;
    end

    empv_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire, .req(s_tuser), .out_fire, .st,
        .in_ready(s_tready), .out_valid(m_tvalid), .cmd
    );

    empv_dp #(.MAX_BACKGROUND(MAX_BACKGROUND), .SCORE_WIDTH(SCORE_WIDTH)) u_dp (
        .aclk, .aresetn, .cmd, .req(s_tuser), .score(s_tdata),
        .p_floor(p_floor_reg), .st, .status(m_tuser), .p_value(pv),
        .lower_rank(lr), .upper_rank(ur)
    );

    assign m_tdata = {5'd0, ur, lr, pv};
endmodule

[hw/rtl/empv_ctrl.sv]
// ----------------------------------------------------------------------------
// empv_ctrl: sequencing FSM
// Steps searches, insert shift, divide and result handoff.
// ----------------------------------------------------------------------------
module empv_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic [1:0]       req,
    input  logic             out_fire,
    input  empv_pkg::stat_t  st,
    output logic             in_ready,
    output logic             out_valid,
    output empv_pkg::cmd_t   cmd
);
    empv_pkg::state_t state_reg, state_next;
    logic [1:0] req_reg;
    logic       pass_reg, pass_next;   // 0 = lower-bound pass of a query

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= empv_pkg::S_IDLE;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
        if (in_fire) req_reg <= req;
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            empv_pkg::S_IDLE: begin
                if (in_fire) begin
                    pass_next = 1'b0;
                    state_next = empv_pkg::S_FIN;
                    if (req == empv_pkg::REQ_INSERT) state_next = empv_pkg::S_SRCH_RD;
                    if (req == empv_pkg::REQ_QUERY)  state_next = empv_pkg::S_SRCH_RD;
                end
            end
            empv_pkg::S_SRCH_RD: begin
                if (req_reg == empv_pkg::REQ_INSERT && st.full)
                    state_next = empv_pkg::S_FIN;
                else if (req_reg == empv_pkg::REQ_QUERY && st.empty)
                    state_next = empv_pkg::S_FIN;
                else if (st.srch_done) begin
                    if (req_reg == empv_pkg::REQ_INSERT) state_next = empv_pkg::S_SHIFT_RD;
                    else if (!pass_reg) pass_next = 1'b1;
                    else state_next = empv_pkg::S_DIV;
                end else
                    state_next = empv_pkg::S_SRCH_CMP;
            end
            empv_pkg::S_SRCH_CMP: state_next = empv_pkg::S_SRCH_RD;
            empv_pkg::S_SHIFT_RD:
                state_next = st.shift_done ? empv_pkg::S_PUT : empv_pkg::S_SHIFT_WR;
            empv_pkg::S_SHIFT_WR: state_next = empv_pkg::S_SHIFT_RD;
            empv_pkg::S_PUT:      state_next = empv_pkg::S_FIN;
            empv_pkg::S_DIV:      if (st.div_done) state_next = empv_pkg::S_FIN;
            empv_pkg::S_FIN:      state_next = empv_pkg::S_OUT;
            empv_pkg::S_OUT:      if (out_fire) state_next = empv_pkg::S_IDLE;
            default:              state_next = empv_pkg::S_IDLE;
        endcase
    end

    // search state S_SRCH_RD issues init on first entry: done by srch_init on load
    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            empv_pkg::S_IDLE: begin
                in_ready      = 1'b1;
                cmd.load      = in_fire;
                cmd.srch_init = in_fire;
                cmd.strict    = (req == empv_pkg::REQ_QUERY);
                cmd.clear     = in_fire && (req == empv_pkg::REQ_CLEAR);
            end
            empv_pkg::S_SRCH_RD: begin
                cmd.rd_mid = 1'b1;
                if (st.srch_done && req_reg == empv_pkg::REQ_QUERY && !pass_reg) begin
                    cmd.save_low  = 1'b1;
                    cmd.srch_init = 1'b1;
                    cmd.strict    = 1'b0;
                end
                if (st.srch_done && req_reg == empv_pkg::REQ_INSERT)
                    cmd.shift_init = 1'b1;
                if (st.srch_done && req_reg == empv_pkg::REQ_QUERY && pass_reg)
                    cmd.div_init = 1'b1;
            end
            empv_pkg::S_SRCH_CMP: cmd.srch_step = 1'b1;
            empv_pkg::S_SHIFT_RD: cmd.rd_shift  = 1'b1;
            empv_pkg::S_SHIFT_WR: cmd.wr_shift  = 1'b1;
            empv_pkg::S_PUT:      cmd.put       = 1'b1;
            empv_pkg::S_DIV:      cmd.div_step  = 1'b1;
            empv_pkg::S_FIN:      cmd.fin       = 1'b1;
            empv_pkg::S_OUT:      out_valid     = 1'b1;
            default: ;
        endcase
    end
endmodule

[hw/rtl/empv_dp.sv]
// ----------------------------------------------------------------------------
// empv_dp: store, bound search, shifter and restoring divider
// Sorted score memory with one read and one write port.
// ----------------------------------------------------------------------------
module empv_dp #(
    parameter int MAX_BACKGROUND = empv_pkg::MAX_BACKGROUND_DEF,
    parameter int SCORE_WIDTH    = empv_pkg::SCORE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  empv_pkg::cmd_t                cmd,
    input  logic [1:0]                    req,
    input  logic [SCORE_WIDTH-1:0]        score,
    input  logic [empv_pkg::PV_W-1:0]     p_floor,
    output empv_pkg::stat_t               st,
    output logic [1:0]                    status,
    output logic [empv_pkg::PV_W-1:0]     p_value,
    output logic [empv_pkg::RANK_W-1:0]   lower_rank,
    output logic [empv_pkg::RANK_W-1:0]   upper_rank
);
    localparam int AW = $clog2(MAX_BACKGROUND);
    localparam int CW = $clog2(MAX_BACKGROUND + 1);
    localparam int NW = CW + 1;          // width of 2N
    localparam int QW = 25;              // quotient bits (value <= 2^24)
    localparam int DW = NW + 1;          // remainder width
    localparam logic [CW-1:0] MAXC = CW'(MAX_BACKGROUND);

    logic [SCORE_WIDTH-1:0] mem [MAX_BACKGROUND];
    logic [SCORE_WIDTH-1:0] key_reg, rd_reg;
    logic [1:0]             req_reg;
    logic                   full_at_load_reg;   // store was full when request taken
    logic [CW-1:0] cnt_reg, lo_reg, hi_reg, low_reg, ptr_reg;
    logic          strict_reg;
    logic [CW-1:0] mid;
    logic [DW-1:0] rem_reg, rem_sub;
    logic          q_bit;
    logic [QW-1:0] quo_reg;
    logic [NW-1:0] n2;
    logic [5:0]    dcnt_reg;
    logic          go_right;
    logic [1:0]    status_reg;
    logic [empv_pkg::PV_W-1:0] pv_reg;
    logic [empv_pkg::RANK_W-1:0] lr_reg, ur_reg;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign n2  = {cnt_reg, 1'b0};
    // signed compare on stored keys
    assign go_right = strict_reg ? ($signed(rd_reg) <  $signed(key_reg))
                                 : ($signed(rd_reg) <= $signed(key_reg));
    // compare, subtract, then shift: first bit is the integer bit
    assign q_bit   = (rem_reg >= DW'(n2));
    assign rem_sub = q_bit ? (rem_reg - DW'(n2)) : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) cnt_reg <= '0;
        else if (cmd.clear) cnt_reg <= '0;
        else if (cmd.put) cnt_reg <= cnt_reg + CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= score;
            req_reg <= req;
            full_at_load_reg <= (cnt_reg >= MAXC);
        end
        if (cmd.srch_init) begin
            lo_reg <= '0;
            hi_reg <= cmd.clear ? '0 : cnt_reg;
            strict_reg <= cmd.strict;
        end
        if (cmd.rd_mid) rd_reg <= mem[mid[AW-1:0]];
        if (cmd.srch_step) begin
            if (go_right) lo_reg <= mid + CW'(1);
            else          hi_reg <= mid;
        end
        if (cmd.save_low) low_reg <= lo_reg;
        if (cmd.shift_init) ptr_reg <= cnt_reg;
        if (cmd.rd_shift) rd_reg <= mem[AW'(ptr_reg - CW'(1))];
        if (cmd.wr_shift) begin
            mem[ptr_reg[AW-1:0]] <= rd_reg;
            ptr_reg <= ptr_reg - CW'(1);
        end
        if (cmd.put) mem[lo_reg[AW-1:0]] <= key_reg;
        if (cmd.div_init) begin
            // dividend (2N - low - up) << 24, bit serial
            rem_reg  <= DW'(n2) - DW'(low_reg) - DW'(lo_reg);
            quo_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= {rem_sub[DW-2:0], 1'b0};
            quo_reg  <= {quo_reg[QW-2:0], q_bit};
            dcnt_reg <= dcnt_reg + 6'd1;
        end
        if (cmd.fin) begin
            status_reg <= empv_pkg::ST_OK;
            pv_reg <= '0;
            lr_reg <= '0;
            ur_reg <= '0;
            if (req_reg == empv_pkg::REQ_INSERT && full_at_load_reg)
                status_reg <= empv_pkg::ST_FULL;
            else if (req_reg == empv_pkg::REQ_QUERY && cnt_reg == '0)
                status_reg <= empv_pkg::ST_EMPTY;
            else if (req_reg == empv_pkg::REQ_QUERY) begin
                lr_reg <= empv_pkg::RANK_W'(low_reg);
                ur_reg <= empv_pkg::RANK_W'(lo_reg);
                if (quo_reg < p_floor) pv_reg <= p_floor;
                else pv_reg <= quo_reg;
                if (p_floor > empv_pkg::PV_W'(empv_pkg::ONE_Q24) &&
                    quo_reg < p_floor)
                    pv_reg <= empv_pkg::PV_W'(empv_pkg::ONE_Q24);
            end
        end
    end

    // quotient bits: first step yields the integer bit, 24 fraction bits follow
    assign st.div_done   = (dcnt_reg == 6'd24) && cmd.div_step;
    assign st.srch_done  = (lo_reg >= hi_reg);
    assign st.shift_done = (ptr_reg == lo_reg);
    assign st.full       = (cnt_reg >= MAXC);
    assign st.empty      = (cnt_reg == '0);
    assign status     = status_reg;
    assign p_value    = pv_reg;
    assign lower_rank = lr_reg;
    assign upper_rank = ur_reg;
endmodule

[hw/rtl/empv_checker.sv]
// ----------------------------------------------------------------------------
// empv_checker: port-level checks
// Watches the top level's handshakes; bound to the top.
// ----------------------------------------------------------------------------
module empv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);
    // one transaction at a time: no input while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_pv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != empv_pkg::ST_OK |-> m_tdata[24:0] == 25'd0)
        else $error("p_value on failed request");
    a_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[37:25] <= m_tdata[50:38])
        else $error("rank order");
endmodule

bind empirical_midrank_p_value_top empv_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
